// ===== rtl/cckb_pkg.sv =====
// Shared widths, codes and types for the clipped color-key sprite blitter.
`timescale 1ns / 1ps

package cckb_pkg;

   localparam int COORD_W     = 16;  // signed world coordinates
   localparam int DIM_W       = 11;  // sprite dimension fields
   localparam int ORIGIN_W    = 18;  // signed framebuffer origin
   localparam int DEST_W      = 20;  // signed origin plus index
   localparam int FB_W        = 13;  // framebuffer size registers
   localparam int OUT_W       = 12;  // framebuffer coordinate outputs
   localparam int ADDR_W      = 24;  // framebuffer word index
   localparam int COLOR_W     = 32;
   localparam int ALPHA_SHIFT = 24;
   localparam int MAX_FB_DIM  = 4096;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register indexes on the configuration port
   localparam logic CSR_FB_WIDTH  = 1'b0;
   localparam logic CSR_FB_HEIGHT = 1'b1;

   // Item kinds on the request channel
   localparam logic FUNC_BEGIN = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   localparam logic [FB_W-1:0] FB_WIDTH_RESET  = FB_W'(640);
   localparam logic [FB_W-1:0] FB_HEIGHT_RESET = FB_W'(480);
   localparam logic [FB_W-1:0] FB_DIM_LIMIT    = FB_W'(MAX_FB_DIM);

   // One framebuffer write still waiting for its address
   typedef struct packed {
      logic [OUT_W-1:0]   dest_x;
      logic [OUT_W-1:0]   dest_y;
      logic [COLOR_W-1:0] color;
   } blit_pix_type;

endpackage

// ===== rtl/cckb_channels.sv =====
// Request and response channel interfaces of the sprite blitter.
`timescale 1ns / 1ps

interface cckb_req_if
   import cckb_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] cam_x;
   logic signed [COORD_W-1:0] cam_y;
   logic [DIM_W-1:0]          sprite_width;
   logic [DIM_W-1:0]          sprite_height;
   logic [COLOR_W-1:0]        pixel_color;

   modport source (output valid, func, pos_x, pos_y, cam_x, cam_y, sprite_width,
                   sprite_height, pixel_color, input ready);
   modport sink (input valid, func, pos_x, pos_y, cam_x, cam_y, sprite_width,
                 sprite_height, pixel_color, output ready);
endinterface

interface cckb_rsp_if
   import cckb_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [OUT_W-1:0]   dest_x;
   logic [OUT_W-1:0]   dest_y;
   logic [ADDR_W-1:0]  word_address;
   logic [COLOR_W-1:0] color;

   modport source (output valid, dest_x, dest_y, word_address, color, input ready);
   modport sink (input valid, dest_x, dest_y, word_address, color, output ready);
endinterface

// ===== rtl/clipped_color_key_sprite_blit.sv =====
// Top level of the clipped color-key sprite blitter.
`timescale 1ns / 1ps

// A begin item sets the sprite origin (center minus half size minus camera)
// and restarts the row/column counters; each following pixel item advances
// the counters and, if its alpha byte is nonzero and it lands inside both the
// even-sized sprite region and the framebuffer, yields one write with its
// coordinates and word address (row * fb_width + column, low 24 bits).
// The block accepts one item per clock unless the output pipeline is full and
// rsp is stalled; a write reaches rsp through the stage register ahead of the
// address multiplier and the output register behind it. Framebuffer size
// registers above 4096 act as 4096; write them only while the block is idle.

module clipped_color_key_sprite_blit
   import cckb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cckb_req_if.sink              req_ch,
   cckb_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [FB_W-1:0]            fb_width_ff, fb_width_in;
   logic [FB_W-1:0]            fb_height_ff, fb_height_in;
   logic signed [ORIGIN_W-1:0] origin_x_ff, origin_x_in;
   logic signed [ORIGIN_W-1:0] origin_y_ff, origin_y_in;
   logic [DIM_W-1:0]           span_cols_ff, span_cols_in;
   logic [DIM_W-1:0]           span_rows_ff, span_rows_in;
   logic [DIM_W-1:0]           row_length_ff, row_length_in;
   logic [DIM_W-1:0]           row_total_ff, row_total_in;
   logic [DIM_W-1:0]           col_index_ff, col_index_in;
   logic [DIM_W-1:0]           row_index_ff, row_index_in;
   logic                       active_ff, active_in;

   logic                       csr_write;
   logic                       csr_index;
   logic [FB_W-1:0]            fw, fh;
   logic                       accept;
   logic                       live_pixel;
   logic [DIM_W:0]             col_next;
   logic signed [DEST_W-1:0]   dx, dy;
   logic                       in_x, in_y;
   logic                       draw;
   logic                       pipe_ready;
   blit_pix_type               pix;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      unique case (csr_index)
         CSR_FB_WIDTH:  csr_prdata = CSR_DATA_W'(fb_width_ff);
         CSR_FB_HEIGHT: csr_prdata = CSR_DATA_W'(fb_height_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      fb_width_in  = fb_width_ff;
      fb_height_in = fb_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FB_WIDTH:  fb_width_in  = csr_pwdata[FB_W-1:0];
            CSR_FB_HEIGHT: fb_height_in = csr_pwdata[FB_W-1:0];
            default:       ;
         endcase
      end
   end

   // Saturate oversized framebuffer registers
   assign fw = (fb_width_ff  > FB_DIM_LIMIT) ? FB_DIM_LIMIT : fb_width_ff;
   assign fh = (fb_height_ff > FB_DIM_LIMIT) ? FB_DIM_LIMIT : fb_height_ff;

   assign req_ch.ready = pipe_ready;
   assign accept       = req_ch.valid && pipe_ready;
   assign live_pixel   = active_ff && (row_index_ff < row_total_ff);

   assign col_next = {1'b0, col_index_ff} + (DIM_W+1)'(1);

   assign dx = DEST_W'(origin_x_ff) + $signed({{(DEST_W-DIM_W){1'b0}}, col_index_ff});
   assign dy = DEST_W'(origin_y_ff) + $signed({{(DEST_W-DIM_W){1'b0}}, row_index_ff});

   assign in_x = !dx[DEST_W-1] && (dx[DEST_W-2:0] < (DEST_W-1)'(fw));
   assign in_y = !dy[DEST_W-1] && (dy[DEST_W-2:0] < (DEST_W-1)'(fh));

   assign draw = (req_ch.func == FUNC_PIXEL) && live_pixel
              && (req_ch.pixel_color[COLOR_W-1:ALPHA_SHIFT] != '0)
              && (col_index_ff < span_cols_ff) && (row_index_ff < span_rows_ff)
              && in_x && in_y;

   assign pix.dest_x = dx[OUT_W-1:0];
   assign pix.dest_y = dy[OUT_W-1:0];
   assign pix.color  = req_ch.pixel_color;

   // Sprite state: begin reloads everything, a live pixel advances the counters
   always_comb begin
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      span_cols_in  = span_cols_ff;
      span_rows_in  = span_rows_ff;
      row_length_in = row_length_ff;
      row_total_in  = row_total_ff;
      col_index_in  = col_index_ff;
      row_index_in  = row_index_ff;
      active_in     = active_ff;
      if (accept) begin
         if (req_ch.func == FUNC_BEGIN) begin
            origin_x_in = ORIGIN_W'(req_ch.pos_x)
                        - $signed(ORIGIN_W'(req_ch.sprite_width[DIM_W-1:1]))
                        - ORIGIN_W'(req_ch.cam_x);
            origin_y_in = ORIGIN_W'(req_ch.pos_y)
                        - $signed(ORIGIN_W'(req_ch.sprite_height[DIM_W-1:1]))
                        - ORIGIN_W'(req_ch.cam_y);
            span_cols_in  = {req_ch.sprite_width[DIM_W-1:1], 1'b0};
            span_rows_in  = {req_ch.sprite_height[DIM_W-1:1], 1'b0};
            row_length_in = req_ch.sprite_width;
            row_total_in  = req_ch.sprite_height;
            col_index_in  = '0;
            row_index_in  = '0;
            active_in     = 1'b1;
         end else if (live_pixel) begin
            if (col_next >= {1'b0, row_length_ff}) begin
               col_index_in = '0;
               row_index_in = row_index_ff + DIM_W'(1);
            end else begin
               col_index_in = col_next[DIM_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff   <= FB_WIDTH_RESET;
         fb_height_ff  <= FB_HEIGHT_RESET;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         span_cols_ff  <= '0;
         span_rows_ff  <= '0;
         row_length_ff <= '0;
         row_total_ff  <= '0;
         col_index_ff  <= '0;
         row_index_ff  <= '0;
         active_ff     <= 1'b0;
      end else begin
         fb_width_ff   <= fb_width_in;
         fb_height_ff  <= fb_height_in;
         origin_x_ff   <= origin_x_in;
         origin_y_ff   <= origin_y_in;
         span_cols_ff  <= span_cols_in;
         span_rows_ff  <= span_rows_in;
         row_length_ff <= row_length_in;
         row_total_ff  <= row_total_in;
         col_index_ff  <= col_index_in;
         row_index_ff  <= row_index_in;
         active_ff     <= active_in;
      end
   end

   cckb_addr u_addr (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid && draw),
      .in_ready (pipe_ready),
      .in_pix   (pix),
      .fb_pitch (fw),
      .rsp      (rsp_ch)
   );

endmodule

// ===== rtl/cckb_addr.sv =====
// Two-register output pipeline: holds a clipped pixel, then forms its word address.
`timescale 1ns / 1ps

module cckb_addr
   import cckb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  blit_pix_type      in_pix,
   input  logic [FB_W-1:0]   fb_pitch,
   cckb_rsp_if.source        rsp
);

   logic                     s1_valid_ff, s1_valid_in;
   blit_pix_type             s1_pix_ff;
   logic                     s2_valid_ff, s2_valid_in;
   blit_pix_type             s2_pix_ff;
   logic [ADDR_W-1:0]        s2_addr_ff;
   logic [OUT_W+FB_W-1:0]    product;
   logic                     s2_load;
   logic                     s1_load;

   assign s2_load  = !s2_valid_ff || rsp.ready;
   assign in_ready = !s1_valid_ff || s2_load;
   assign s1_load  = in_valid && in_ready;

   assign product = (OUT_W+FB_W)'(s1_pix_ff.dest_y) * (OUT_W+FB_W)'(fb_pitch);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_pix_ff <= in_pix;
      end
      if (s2_load) begin
         s2_pix_ff  <= s1_pix_ff;
         s2_addr_ff <= product[ADDR_W-1:0] + ADDR_W'(s1_pix_ff.dest_x);
      end
   end

   assign rsp.valid        = s2_valid_ff;
   assign rsp.dest_x       = s2_pix_ff.dest_x;
   assign rsp.dest_y       = s2_pix_ff.dest_y;
   assign rsp.word_address = s2_addr_ff;
   assign rsp.color        = s2_pix_ff.color;

endmodule
